// ===== sv/gce_pkg.sv =====
// Shared types, constants and helpers for the grouped convolution engine.
// Used by gce_div and grouped_conv2d_engine; depends on nothing else.
`timescale 1ns / 1ps
package gce_pkg;

   localparam int DEF_INPUT_DEPTH  = 16384;
   localparam int DEF_WEIGHT_DEPTH = 4096;
   localparam int DEF_MAX_CHANNELS = 64;

   // Width of the shared divider operands (padded extents and channel counts).
   localparam int DIV_W   = 10;
   // Signed width of input row and column coordinates.
   localparam int COORD_W = 16;
   // Signed width of flat input addresses while they are being built.
   localparam int ADDR_W  = 26;
   // Width of the running weight address.
   localparam int WA_W    = 24;

   typedef enum logic [1:0] {
      OP_LOAD_INPUT  = 2'd0,
      OP_LOAD_WEIGHT = 2'd1,
      OP_LOAD_BIAS   = 2'd2,
      OP_COMPUTE     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_OUTSIDE = 2'd1,
      STATUS_KERNEL  = 2'd2,
      STATUS_UNUSED  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CSR_IN_CHANNELS  = 3'd0,
      CSR_IN_HEIGHT    = 3'd1,
      CSR_IN_WIDTH     = 3'd2,
      CSR_OUT_CHANNELS = 3'd3,
      CSR_GROUPS       = 3'd4,
      CSR_KERNEL_SIZE  = 3'd5,
      CSR_STRIDE_DIL   = 3'd6,
      CSR_PADS         = 3'd7
   } csr_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_SPAN_H,
      S_SPAN_W,
      S_DIV_GO,
      S_DIV_WAIT,
      S_GM,
      S_M_HI,
      S_M_WI,
      S_M_HW,
      S_M_DROW,
      S_M_ICH,
      S_M_CHAN,
      S_M_ROW,
      S_M_OC,
      S_M_KH,
      S_M_KW,
      S_RUN,
      S_DRAIN,
      S_OUT
   } state_type;

   // A zero nibble counts as one.
   function automatic logic [3:0] nz_nib(input logic [3:0] v);
      return (v == 4'd0) ? 4'd1 : v;
   endfunction

endpackage

// ===== sv/gce_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on gce_pkg for the operand width.
`timescale 1ns / 1ps
module gce_div
   import gce_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic             busy,
   output logic [DIV_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DIV_W:0]   trial;
   logic             fits;

   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign fits  = trial >= {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIV_W);
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? DIV_W'(trial - {1'b0, divisor}) : trial[DIV_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

// ===== sv/grouped_conv2d_engine.sv =====
// Top level of the grouped 2D convolution engine (NCHW, int32 wrap-around).
// Depends on gce_pkg and on gce_div, the shared iterative divider.
//
//   port group   direction  handshake          carries
//   req_*        in         req_valid/ready    load or compute request
//   rsp_*        out        rsp_valid/ready    conv_value and status
//   csr_*        in         csr_wr_en          configuration register write
//
// A load request writes its store at once when it is taken.
// A compute request runs a setup of five divisions on the shared divider and
// thirteen steps, each using the shared multiplier, then walks the cpg * kH * kW
// kernel taps, one multiply-accumulate per cycle, and then drains the
// accumulator. A kernel larger than the padded input, or an output position or
// channel out of range, ends the request early with its status.
// Reset returns control to idle and configuration to its defaults; the stores are not cleared.
// The request side is ready whenever the sequencer is idle; a finished
// result waits in the output register while the next request is taken.
`timescale 1ns / 1ps
module grouped_conv2d_engine
   import gce_pkg::*;
#(
   parameter int INPUT_DEPTH  = DEF_INPUT_DEPTH,
   parameter int WEIGHT_DEPTH = DEF_WEIGHT_DEPTH,
   parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_op,
   input  logic [13:0]        req_index,
   input  logic signed [31:0] req_value,
   input  logic [5:0]         req_out_channel,
   input  logic [7:0]         req_out_row,
   input  logic [7:0]         req_out_col,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_conv_value,
   output logic [1:0]         rsp_status,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wr_data
);

   localparam int IA_W = (INPUT_DEPTH > 1) ? $clog2(INPUT_DEPTH) : 1;
   localparam int WI_W = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;
   localparam int BA_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

   // Configuration registers.
   logic [6:0]  cfg_c_ff, cfg_m_ff, cfg_g_ff;
   logic [8:0]  cfg_h_ff, cfg_w_ff;
   logic [7:0]  cfg_k_ff;
   logic [15:0] cfg_sd_ff, cfg_pad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_c_ff   <= 7'd1;
         cfg_h_ff   <= 9'd1;
         cfg_w_ff   <= 9'd1;
         cfg_m_ff   <= 7'd1;
         cfg_g_ff   <= 7'd1;
         cfg_k_ff   <= 8'h11;
         cfg_sd_ff  <= 16'h1111;
         cfg_pad_ff <= 16'h0000;
      end else if (csr_wr_en) begin
         unique case (csr_type'(csr_index))
            CSR_IN_CHANNELS:  cfg_c_ff   <= csr_wr_data[6:0];
            CSR_IN_HEIGHT:    cfg_h_ff   <= csr_wr_data[8:0];
            CSR_IN_WIDTH:     cfg_w_ff   <= csr_wr_data[8:0];
            CSR_OUT_CHANNELS: cfg_m_ff   <= csr_wr_data[6:0];
            CSR_GROUPS:       cfg_g_ff   <= csr_wr_data[6:0];
            CSR_KERNEL_SIZE:  cfg_k_ff   <= csr_wr_data[7:0];
            CSR_STRIDE_DIL:   cfg_sd_ff  <= csr_wr_data;
            CSR_PADS:         cfg_pad_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Decoded geometry; zero kernel, stride, dilation and group fields count as one.
   logic [3:0] kh, kw, sh, sw, dh, dw, pt, pl, pb, pr;
   logic [6:0] g_n;
   logic [DIV_W-1:0] ph, pw;

   assign kh  = nz_nib(cfg_k_ff[3:0]);
   assign kw  = nz_nib(cfg_k_ff[7:4]);
   assign sh  = nz_nib(cfg_sd_ff[3:0]);
   assign sw  = nz_nib(cfg_sd_ff[7:4]);
   assign dh  = nz_nib(cfg_sd_ff[11:8]);
   assign dw  = nz_nib(cfg_sd_ff[15:12]);
   assign pt  = cfg_pad_ff[3:0];
   assign pl  = cfg_pad_ff[7:4];
   assign pb  = cfg_pad_ff[11:8];
   assign pr  = cfg_pad_ff[15:12];
   assign g_n = (cfg_g_ff == 7'd0) ? 7'd1 : cfg_g_ff;
   assign ph  = DIV_W'(cfg_h_ff) + DIV_W'(pt) + DIV_W'(pb);
   assign pw  = DIV_W'(cfg_w_ff) + DIV_W'(pl) + DIV_W'(pr);

   // Sequencer and datapath registers.
   state_type state_ff, state_in;
   logic [2:0] div_sel_ff, div_sel_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       v1_ff, v1_in, v2_ff, v2_in, use1_ff, use1_in;
   logic [5:0] oc_ff, oc_in;
   logic [7:0] orow_ff, orow_in, ocol_ff, ocol_in;
   logic [7:0] span_h_ff, span_h_in, span_w_ff, span_w_in;
   logic [DIV_W-1:0] hout_ff, hout_in, wout_ff, wout_in;
   logic [6:0] cpg_ff, cpg_in, mpg_ff, mpg_in, grp_ff, grp_in, c_ff, c_in;
   logic [3:0] a_ff, a_in, b_ff, b_in;
   logic signed [COORD_W-1:0] hi0_ff, hi0_in, wi0_ff, wi0_in, hi_ff, hi_in, wi_ff, wi_in;
   logic signed [ADDR_W-1:0] hw_ff, hw_in, drow_ff, drow_in;
   logic signed [ADDR_W-1:0] chan_ff, chan_in, row_ff, row_in;
   logic signed [ADDR_W-1:0] rowoff_ff, rowoff_in;
   logic [ADDR_W-1:0] tmp_ff, tmp_in;
   logic [WA_W-1:0]   wa_ff, wa_in;
   logic [31:0] prod_ff, prod_in, acc_ff, acc_in;
   logic [31:0] res_value_ff, res_value_in, rsp_value_ff, rsp_value_in;
   status_type  res_status_ff, res_status_in, rsp_status_ff, rsp_status_in;

   // Store read data.
   logic [31:0] x_rd_ff, w_rd_ff, bias_rd_ff;

   // Shared multiplier: setup products in the setup states, taps in the walk.
   logic [31:0] mul_a, mul_b, mul_res;
   assign mul_res = mul_a * mul_b;

   // Shared divider.
   logic             div_start, div_busy;
   logic [DIV_W-1:0] div_dividend, div_divisor, div_q;

   gce_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_q)
   );

   always_comb begin
      unique case (div_sel_ff)
         3'd0: begin
            div_dividend = (DIV_W'(span_h_ff) > ph) ? '0 : DIV_W'(ph - DIV_W'(span_h_ff));
            div_divisor  = DIV_W'(sh);
         end
         3'd1: begin
            div_dividend = (DIV_W'(span_w_ff) > pw) ? '0 : DIV_W'(pw - DIV_W'(span_w_ff));
            div_divisor  = DIV_W'(sw);
         end
         3'd2: begin
            div_dividend = DIV_W'(cfg_c_ff);
            div_divisor  = DIV_W'(g_n);
         end
         3'd3: begin
            div_dividend = DIV_W'(cfg_m_ff);
            div_divisor  = DIV_W'(g_n);
         end
         default: begin
            div_dividend = DIV_W'(oc_ff);
            div_divisor  = DIV_W'(mpg_ff);
         end
      endcase
   end

   // Current tap: position test and flat addresses.
   logic signed [ADDR_W-1:0] ia;
   logic tap_ok, ia_ok, wa_ok;
   logic [31:0] oc32, idx32;

   assign ia     = row_ff + ADDR_W'(wi_ff);
   assign tap_ok = (hi_ff >= 0) && (hi_ff < $signed(COORD_W'(cfg_h_ff)))
                && (wi_ff >= 0) && (wi_ff < $signed(COORD_W'(cfg_w_ff)));
   assign ia_ok  = tap_ok && (ADDR_W'(unsigned'(ia)) < ADDR_W'(INPUT_DEPTH));
   assign wa_ok  = wa_ff < WA_W'(WEIGHT_DEPTH);
   assign oc32   = 32'(oc_ff);
   assign idx32  = 32'(req_index);

   logic req_fire, rsp_free;
   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      div_sel_in    = div_sel_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      v1_in         = 1'b0;
      use1_in       = 1'b0;
      v2_in         = v1_ff;
      prod_in       = use1_ff ? mul_res : 32'd0;
      acc_in        = v2_ff ? acc_ff + prod_ff : acc_ff;
      oc_in         = oc_ff;
      orow_in       = orow_ff;
      ocol_in       = ocol_ff;
      span_h_in     = span_h_ff;
      span_w_in     = span_w_ff;
      hout_in       = hout_ff;
      wout_in       = wout_ff;
      cpg_in        = cpg_ff;
      mpg_in        = mpg_ff;
      grp_in        = grp_ff;
      c_in          = c_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      hi0_in        = hi0_ff;
      wi0_in        = wi0_ff;
      hi_in         = hi_ff;
      wi_in         = wi_ff;
      hw_in         = hw_ff;
      drow_in       = drow_ff;
      chan_in       = chan_ff;
      row_in        = row_ff;
      rowoff_in     = rowoff_ff;
      tmp_in        = tmp_ff;
      wa_in         = wa_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      div_start     = 1'b0;
      mul_a         = x_rd_ff;
      mul_b         = w_rd_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && (op_type'(req_op) == OP_COMPUTE)) begin
               oc_in    = req_out_channel;
               orow_in  = req_out_row;
               ocol_in  = req_out_col;
               state_in = S_SPAN_H;
            end
         end
         S_SPAN_H: begin
            mul_a     = 32'(kh - 4'd1);
            mul_b     = 32'(dh);
            span_h_in = mul_res[7:0] + 8'd1;
            if ((DIV_W'(kh) > ph) || (DIV_W'(kw) > pw)) begin
               res_value_in  = '0;
               res_status_in = STATUS_KERNEL;
               state_in      = S_OUT;
            end else begin
               state_in = S_SPAN_W;
            end
         end
         S_SPAN_W: begin
            mul_a      = 32'(kw - 4'd1);
            mul_b      = 32'(dw);
            span_w_in  = mul_res[7:0] + 8'd1;
            div_sel_in = 3'd0;
            state_in   = S_DIV_GO;
         end
         S_DIV_GO: begin
            div_start = 1'b1;
            state_in  = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (!div_busy) begin
               unique case (div_sel_ff)
                  3'd0: hout_in = (DIV_W'(span_h_ff) > ph) ? '0 : div_q + DIV_W'(1);
                  3'd1: wout_in = (DIV_W'(span_w_ff) > pw) ? '0 : div_q + DIV_W'(1);
                  3'd2: cpg_in  = div_q[6:0];
                  3'd3: mpg_in  = div_q[6:0];
                  default: grp_in = div_q[6:0];
               endcase
               if (div_sel_ff == 3'd3) begin
                  state_in = S_GM;
               end else if (div_sel_ff == 3'd4) begin
                  state_in = S_M_HI;
               end else begin
                  div_sel_in = div_sel_ff + 3'd1;
                  state_in   = S_DIV_GO;
               end
            end
         end
         S_GM: begin
            // Reject positions outside the output and channels out of range or that no group covers.
            mul_a = 32'(g_n);
            mul_b = 32'(mpg_ff);
            if ((DIV_W'(orow_ff) >= hout_ff) || (DIV_W'(ocol_ff) >= wout_ff)
                || (oc32 >= 32'(cfg_m_ff)) || (oc32 >= 32'(MAX_CHANNELS))
                || (mpg_ff == 7'd0) || (oc32 >= mul_res)) begin
               res_value_in  = '0;
               res_status_in = STATUS_OUTSIDE;
               state_in      = S_OUT;
            end else begin
               div_sel_in = 3'd4;
               state_in   = S_DIV_GO;
            end
         end
         S_M_HI: begin
            mul_a    = 32'(orow_ff);
            mul_b    = 32'(sh);
            hi0_in   = $signed(mul_res[COORD_W-1:0]) - $signed(COORD_W'(pt));
            hi_in    = $signed(mul_res[COORD_W-1:0]) - $signed(COORD_W'(pt));
            state_in = S_M_WI;
         end
         S_M_WI: begin
            mul_a    = 32'(ocol_ff);
            mul_b    = 32'(sw);
            wi0_in   = $signed(mul_res[COORD_W-1:0]) - $signed(COORD_W'(pl));
            wi_in    = $signed(mul_res[COORD_W-1:0]) - $signed(COORD_W'(pl));
            state_in = S_M_HW;
         end
         S_M_HW: begin
            mul_a    = 32'(cfg_h_ff);
            mul_b    = 32'(cfg_w_ff);
            hw_in    = $signed(mul_res[ADDR_W-1:0]);
            state_in = S_M_DROW;
         end
         S_M_DROW: begin
            mul_a    = 32'(dh);
            mul_b    = 32'(cfg_w_ff);
            drow_in  = $signed(mul_res[ADDR_W-1:0]);
            state_in = S_M_ICH;
         end
         S_M_ICH: begin
            mul_a    = 32'(grp_ff);
            mul_b    = 32'(cpg_ff);
            tmp_in   = mul_res[ADDR_W-1:0];
            state_in = S_M_CHAN;
         end
         S_M_CHAN: begin
            mul_a    = 32'(tmp_ff);
            mul_b    = 32'(unsigned'(hw_ff));
            chan_in  = $signed(mul_res[ADDR_W-1:0]);
            state_in = S_M_ROW;
         end
         S_M_ROW: begin
            // The first-row offset is kept so each channel restarts from it.
            mul_a     = 32'(hi0_ff);
            mul_b     = 32'(cfg_w_ff);
            rowoff_in = $signed(mul_res[ADDR_W-1:0]);
            row_in    = chan_ff + $signed(mul_res[ADDR_W-1:0]);
            state_in  = S_M_OC;
         end
         S_M_OC: begin
            mul_a    = 32'(oc_ff);
            mul_b    = 32'(cpg_ff);
            tmp_in   = mul_res[ADDR_W-1:0];
            state_in = S_M_KH;
         end
         S_M_KH: begin
            mul_a    = 32'(tmp_ff);
            mul_b    = 32'(kh);
            tmp_in   = mul_res[ADDR_W-1:0];
            state_in = S_M_KW;
         end
         S_M_KW: begin
            mul_a    = 32'(tmp_ff);
            mul_b    = 32'(kw);
            wa_in    = mul_res[WA_W-1:0];
            c_in     = '0;
            a_in     = '0;
            b_in     = '0;
            acc_in   = '0;
            state_in = (cpg_ff == 7'd0) ? S_DRAIN : S_RUN;
         end
         S_RUN: begin
            // Issue one tap per cycle; padded taps and stray addresses add zero.
            v1_in   = 1'b1;
            use1_in = ia_ok && wa_ok;
            wa_in   = wa_ff + WA_W'(1);
            if (b_ff != kw - 4'd1) begin
               b_in  = b_ff + 4'd1;
               wi_in = wi_ff + $signed(COORD_W'(dw));
            end else begin
               b_in  = '0;
               wi_in = wi0_ff;
               if (a_ff != kh - 4'd1) begin
                  a_in   = a_ff + 4'd1;
                  hi_in  = hi_ff + $signed(COORD_W'(dh));
                  row_in = row_ff + drow_ff;
               end else begin
                  a_in    = '0;
                  hi_in   = hi0_ff;
                  chan_in = chan_ff + hw_ff;
                  row_in  = chan_ff + hw_ff + rowoff_ff;
                  if (c_ff != cpg_ff - 7'd1) begin
                     c_in = c_ff + 7'd1;
                  end else begin
                     state_in = S_DRAIN;
                  end
               end
            end
         end
         S_DRAIN: begin
            if (!v1_ff && !v2_ff) begin
               res_value_in  = acc_ff + bias_rd_ff;
               res_status_in = STATUS_OK;
               state_in      = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_value_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         div_sel_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         use1_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_sel_ff   <= div_sel_in;
         rsp_valid_ff <= rsp_valid_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         use1_ff      <= use1_in;
      end
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      oc_ff         <= oc_in;
      orow_ff       <= orow_in;
      ocol_ff       <= ocol_in;
      span_h_ff     <= span_h_in;
      span_w_ff     <= span_w_in;
      hout_ff       <= hout_in;
      wout_ff       <= wout_in;
      cpg_ff        <= cpg_in;
      mpg_ff        <= mpg_in;
      grp_ff        <= grp_in;
      c_ff          <= c_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      hi0_ff        <= hi0_in;
      wi0_ff        <= wi0_in;
      hi_ff         <= hi_in;
      wi_ff         <= wi_in;
      hw_ff         <= hw_in;
      drow_ff       <= drow_in;
      chan_ff       <= chan_in;
      row_ff        <= row_in;
      rowoff_ff     <= rowoff_in;
      tmp_ff        <= tmp_in;
      wa_ff         <= wa_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Stores: one write port for loads, one registered read port each.
   logic [31:0] input_mem  [INPUT_DEPTH];
   logic [31:0] weight_mem [WEIGHT_DEPTH];
   logic [31:0] bias_mem   [MAX_CHANNELS];

   always_ff @(posedge clock) begin
      if (req_fire && (op_type'(req_op) == OP_LOAD_INPUT)
          && (idx32 < 32'(INPUT_DEPTH))) begin
         input_mem[idx32[IA_W-1:0]] <= req_value;
      end
      if (req_fire && (op_type'(req_op) == OP_LOAD_WEIGHT)
          && (idx32 < 32'(WEIGHT_DEPTH))) begin
         weight_mem[idx32[WI_W-1:0]] <= req_value;
      end
      if (req_fire && (op_type'(req_op) == OP_LOAD_BIAS)
          && (idx32 < 32'(MAX_CHANNELS))) begin
         bias_mem[idx32[BA_W-1:0]] <= req_value;
      end
      x_rd_ff    <= input_mem[ia[IA_W-1:0]];
      w_rd_ff    <= weight_mem[wa_ff[WI_W-1:0]];
      bias_rd_ff <= bias_mem[oc32[BA_W-1:0]];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_conv_value = rsp_value_ff;
   assign rsp_status     = rsp_status_ff;

endmodule
